// ===== rtl/lbp_pkg.sv =====
`default_nettype none

package lbp_pkg;

   // Default frame limits handed to the top-level parameters.
   localparam int unsigned MAX_WIDTH_DEF  = 1024;
   localparam int unsigned MAX_HEIGHT_DEF = 4096;

   // Configuration register layout.
   localparam int unsigned WIDTH_REG_W  = 11;
   localparam int unsigned HEIGHT_REG_W = 13;
   localparam int unsigned CSR_DATA_W   = 13;
   localparam int unsigned CSR_IDX_W    = 1;
   localparam int unsigned WIDTH_RESET  = 640;
   localparam int unsigned HEIGHT_RESET = 480;
   localparam int unsigned SIZE_MIN     = 3;

   // Pixel and code widths.
   localparam int unsigned PIXEL_W = 8;
   localparam int unsigned CODE_W  = 8;

   // Entries in the result queue.
   localparam int unsigned RSP_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // One pixel with its resolved column neighbors, handed to the window.
   typedef struct packed {
      logic      emit;
      logic      last;
      pixel_type px;
      pixel_type top;
      pixel_type mid;
   } lbp_item_type;

   // One finished pattern code.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last;
   } lbp_result_type;

endpackage

`default_nettype wire

// ===== rtl/lbp_3x3_stream_core.sv =====
`default_nettype none

// 3x3 local binary pattern engine for a raster pixel stream. It takes one pixel per clock
// when the result side keeps up: the two line stores have a registered read port and are
// read at the pixel's column on transfer and written back in the next cycle, with a bypass
// when the same column is read again at once (a frame start on column 0). A pattern code
// enters the result queue in the cycle after the centre's bottom-right neighbor is taken in,
// and is held in a queue entry register before it can be transferred out. The queue holds
// four entries; req_stall rises when that queue plus the pixel in flight could fill it.
// Border rows and columns give no code, so a frame yields (width-2) by
// (height-2) codes, the last one marked with rsp_frame_last. Size registers may only be
// written while no pixel is in flight; values below 3 act as 3 and values above the
// parameter limits act as the limits. There is no clearing pass after reset: a high-water
// mark of written columns makes unwritten line store entries read as zero.
module lbp_3x3_stream_core #(
   parameter int unsigned MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Pixel input channel.
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [lbp_pkg::PIXEL_W-1:0]      req_pixel,
   input  wire logic                             req_frame_start,
   // Pattern code output channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [lbp_pkg::CODE_W-1:0]            rsp_pattern_code,
   output logic                                  rsp_frame_last,
   // Configuration write port.
   input  wire logic                             csr_we,
   input  wire logic [lbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lbp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lbp_pkg::*;

   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
   localparam int unsigned WV_W   = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HV_W   = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned WCMP_W = (WV_W > WIDTH_REG_W) ? WV_W : WIDTH_REG_W;
   localparam int unsigned HCMP_W = (HV_W > HEIGHT_REG_W) ? HV_W : HEIGHT_REG_W;
   localparam int unsigned CNT_W  = $clog2(RSP_DEPTH + 1);
   localparam int unsigned WIDTH_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam int unsigned HEIGHT_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

   // Frame size, held already clamped.
   logic [WV_W-1:0]   w_ff, w_in;
   logic [HV_W-1:0]   h_ff, h_in;
   logic [WCMP_W-1:0] wr_w;
   logic [HCMP_W-1:0] wr_h;

   // Position of the next pixel and high-water mark of written columns.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [WV_W-1:0]   fill_ff, fill_in;

   // Position logic for the pixel on the input.
   logic              accept;
   logic [COL_W-1:0]  start_col, cur_col;
   logic [ROW_W-1:0]  start_row, cur_row;
   logic [HV_W-1:0]   row_a;
   logic              col_wrap, col_last, row_last;

   // Second stage: memory data returns here.
   logic              s1_valid_ff;
   logic [COL_W-1:0]  s1_col_ff;
   pixel_type         s1_px_ff;
   logic              s1_emit_ff;
   logic              s1_last_ff;
   logic              s1_fwd_ff;
   logic              s1_rd_ok_ff;
   pixel_type         fwd_top_ff;
   pixel_type         fwd_mid_ff;
   pixel_type         upper_rdata, middle_rdata;
   pixel_type         s1_top, s1_mid;

   lbp_item_type      item;
   logic              res_valid;
   lbp_result_type    res;
   lbp_result_type    rsp_data;
   logic [CNT_W-1:0]  q_level;

   // Clamp size writes into the legal range.
   always_comb begin
      wr_w = WCMP_W'(csr_wdata[WIDTH_REG_W-1:0]);
      wr_h = HCMP_W'(csr_wdata[HEIGHT_REG_W-1:0]);
      w_in = w_ff;
      h_in = h_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               if (wr_w < WCMP_W'(SIZE_MIN)) begin
                  w_in = WV_W'(SIZE_MIN);
               end else if (wr_w > WCMP_W'(MAX_WIDTH)) begin
                  w_in = WV_W'(MAX_WIDTH);
               end else begin
                  w_in = WV_W'(wr_w);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (wr_h < HCMP_W'(SIZE_MIN)) begin
                  h_in = HV_W'(SIZE_MIN);
               end else if (wr_h > HCMP_W'(MAX_HEIGHT)) begin
                  h_in = HV_W'(MAX_HEIGHT);
               end else begin
                  h_in = HV_W'(wr_h);
               end
            end
            default: begin
               w_in = w_ff;
               h_in = h_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= WV_W'(WIDTH_RST);
         h_ff <= HV_W'(HEIGHT_RST);
      end else begin
         w_ff <= w_in;
         h_ff <= h_in;
      end
   end

   // Input throttle: leave room in the result queue for the pixel in flight and a new one.
   assign req_stall = (CNT_W'(q_level) + CNT_W'(s1_valid_ff)) >= CNT_W'(RSP_DEPTH);
   assign accept    = req_valid && !req_stall;

   // Resolve the position of the incoming pixel and the one after it.
   always_comb begin
      start_col = req_frame_start ? '0 : col_ff;
      start_row = req_frame_start ? '0 : row_ff;
      col_wrap  = WV_W'(start_col) >= w_ff;
      row_a     = col_wrap ? HV_W'(start_row) + HV_W'(1) : HV_W'(start_row);
      cur_col   = col_wrap ? '0 : start_col;
      cur_row   = (row_a >= h_ff) ? '0 : row_a[ROW_W-1:0];
      col_last  = WV_W'(cur_col) == (w_ff - WV_W'(1));
      row_last  = HV_W'(cur_row) == (h_ff - HV_W'(1));
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : cur_row + ROW_W'(1);
         end else begin
            col_in = cur_col + COL_W'(1);
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // First stage to second stage: the read is issued on transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_fwd_ff   <= accept && s1_valid_ff && (s1_col_ff == cur_col);
      end
   end

   // The bypass carries the values being written: the old middle row and the new pixel.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= cur_col;
         s1_px_ff    <= req_pixel;
         s1_emit_ff  <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
         s1_last_ff  <= col_last && row_last;
         s1_rd_ok_ff <= WV_W'(cur_col) < fill_ff;
         fwd_top_ff  <= s1_mid;
         fwd_mid_ff  <= s1_px_ff;
      end
   end

   // Column neighbors: bypass the write still in flight, zero for never-written columns.
   always_comb begin
      if (s1_fwd_ff) begin
         s1_top = fwd_top_ff;
         s1_mid = fwd_mid_ff;
      end else if (s1_rd_ok_ff) begin
         s1_top = upper_rdata;
         s1_mid = middle_rdata;
      end else begin
         s1_top = '0;
         s1_mid = '0;
      end
   end

   // Advance the high-water mark as new columns are written.
   always_comb begin
      fill_in = fill_ff;
      if (s1_valid_ff && (WV_W'(s1_col_ff) >= fill_ff)) begin
         fill_in = WV_W'(s1_col_ff) + WV_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Line stores: the middle row moves up, the new pixel becomes the middle row.
   lbp_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_mid),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (upper_rdata)
   );

   lbp_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (middle_rdata)
   );

   // Window and code compare.
   always_comb begin
      item.emit = s1_emit_ff;
      item.last = s1_last_ff;
      item.px   = s1_px_ff;
      item.top  = s1_top;
      item.mid  = s1_mid;
   end

   lbp_win u_win (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (item),
      .res_valid  (res_valid),
      .res        (res)
   );

   lbp_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .level     (q_level)
   );

   assign rsp_pattern_code = rsp_data.code;
   assign rsp_frame_last   = rsp_data.last;

   // After a transfer the stored column lies inside the frame.
   assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we |=> WV_W'(col_ff) < w_ff)
      else $error("column position outside the frame");

   // The high-water mark never passes the line store depth.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WV_W'(MAX_WIDTH))
      else $error("line store fill mark out of range");

   // A bypass is only taken right behind a write to the same column.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_fwd_ff |-> $past(s1_valid_ff) && (s1_col_ff == $past(s1_col_ff)))
      else $error("line store bypass without a matching write");

endmodule

`default_nettype wire

// ===== rtl/lbp_ram.sv =====
`default_nettype none

module lbp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; a read and a write to the same entry return old data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lbp_win.sv =====
`default_nettype none

module lbp_win (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire lbp_pkg::lbp_item_type item,
   output logic                       res_valid,
   output lbp_pkg::lbp_result_type    res
);
   import lbp_pkg::*;

   // Window slots: 0/1 top row, 2/3 middle row, 4/5 bottom row; odd slots are newer.
   pixel_type win_ff [6];
   pixel_type win_in [6];
   pixel_type centre;

   // Compare the eight neighbors with the centre of the completed window.
   always_comb begin
      centre        = win_ff[3];
      res.code[7]   = win_ff[0] > centre;
      res.code[6]   = win_ff[1] > centre;
      res.code[5]   = item.top  > centre;
      res.code[4]   = item.mid  > centre;
      res.code[3]   = item.px   > centre;
      res.code[2]   = win_ff[5] > centre;
      res.code[1]   = win_ff[4] > centre;
      res.code[0]   = win_ff[2] > centre;
      res.last      = item.last;
      res_valid     = item_valid && item.emit;
   end

   // Shift the window by one column for every pixel.
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = item.top;
      win_in[2] = win_ff[3];
      win_in[3] = item.mid;
      win_in[4] = win_ff[5];
      win_in[5] = item.px;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (item_valid) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lbp_rsp_queue.sv =====
`default_nettype none

module lbp_rsp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire lbp_pkg::lbp_result_type    push_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output lbp_pkg::lbp_result_type         rsp_data,
   output logic [$clog2(DEPTH+1)-1:0]      level
);
   import lbp_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   lbp_result_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] level_ff, level_in;
   logic             pop;

   assign rsp_valid = level_ff != '0;
   assign rsp_data  = entry_ff[head_ff];
   assign level     = level_ff;
   assign pop       = rsp_valid && !rsp_stall;

   // Pointer and fill level update for a push, a transfer out, or both.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      level_in = level_ff;
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + CNT_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   // The upstream throttle must keep the queue from overflowing.
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> level_ff < CNT_W'(DEPTH))
      else $error("result queue overflow");

   // A transfer out without a push drops the level by one.
   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> level_ff == $past(level_ff) - CNT_W'(1))
      else $error("result queue level did not drop after a transfer");

   // The fill level never passes the number of entries.
   assert property (@(posedge clock) disable iff (reset)
      level_ff <= CNT_W'(DEPTH))
      else $error("result queue level out of range");

endmodule

`default_nettype wire

// ===== verif/lbp_3x3_stream_core_test.sv =====
`timescale 1ns / 100ps

module lbp_3x3_stream_core_test;
   import lbp_pkg::*;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned REPORT_MAX   = 10;

   // How a directed row is checked: by the predictor, not at all, or against a typed-in result.
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_NONE,
      ROW_CODE
   } row_check_type;

   typedef enum logic [1:0] {
      IDLE_RSP_HEAVY,
      IDLE_REQ_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   typedef struct packed {
      pixel_type         px;
      logic              start;
      row_check_type     chk;
      logic [CODE_W-1:0] code;
      logic              last;
   } directed_row_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] width_data;
      logic [CSR_DATA_W-1:0] height_data;
      int unsigned           items;
      idle_mode_type         mode;
   } size_phase_type;

   // Directed frames at 3x3, one code each but for the one cut short: all neighbors
   // brighter, a frame start cutting a frame short, all neighbors darker, and a frame
   // that follows on without a frame start.
   localparam directed_row_type DIRECTED_ROWS [29] = '{
      '{8'd255, 1'b1, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_CODE,  8'hFF, 1'b1},
      '{8'd7,   1'b1, ROW_NONE,  8'h00, 1'b0},
      '{8'd200, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b1, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd255, 1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_NONE,  8'h00, 1'b0},
      '{8'd0,   1'b0, ROW_CODE,  8'h00, 1'b1},
      '{8'd10,  1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd200, 1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd30,  1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd40,  1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd100, 1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd160, 1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd250, 1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd70,  1'b0, ROW_MODEL, 8'h00, 1'b0},
      '{8'd120, 1'b0, ROW_MODEL, 8'h00, 1'b0}
   };

   // Random phases: sizes below the minimum, above the limits, the widest row,
   // the tallest frame, and shrinking sizes in the middle of a frame.
   localparam size_phase_type SIZE_PHASES [9] = '{
      '{13'd5,    13'd4,    100, IDLE_RSP_HEAVY},
      '{13'h1800, 13'd1,    60,  IDLE_RSP_HEAVY},
      '{13'd1024, 13'd2,    560, IDLE_RSP_HEAVY},
      '{13'd7,    13'h1FFF, 100, IDLE_REQ_HEAVY},
      '{13'd11,   13'd6,    100, IDLE_REQ_HEAVY},
      '{13'd4,    13'd5,    80,  IDLE_REQ_HEAVY},
      '{13'd3,    13'd3,    70,  IDLE_NONE},
      '{13'd2047, 13'd0,    40,  IDLE_NONE},
      '{13'd9,    13'd4,    60,  IDLE_NONE}
   };

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   pixel_type             req_pixel       = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [CODE_W-1:0]     rsp_pattern_code;
   logic                  rsp_frame_last;
   logic                  csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   // Codes still owed by the block, oldest first.
   lbp_result_type pending_codes[$];

   // Predictor state: two line stores, the two older window columns and the position.
   pixel_type               upper_row_px  [MAX_WIDTH_DEF];
   pixel_type               middle_row_px [MAX_WIDTH_DEF];
   pixel_type               win_top [2];
   pixel_type               win_mid [2];
   pixel_type               win_bot [2];
   int unsigned             col_at;
   int unsigned             row_at;
   logic [WIDTH_REG_W-1:0]  width_setting;
   logic [HEIGHT_REG_W-1:0] height_setting;

   lbp_3x3_stream_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pattern_code (rsp_pattern_code),
      .rsp_frame_last   (rsp_frame_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_lbp_state();
      foreach (upper_row_px[i]) begin
         upper_row_px[i]  = '0;
         middle_row_px[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
         win_top[i] = '0;
         win_mid[i] = '0;
         win_bot[i] = '0;
      end
      col_at         = 0;
      row_at         = 0;
      width_setting  = WIDTH_RESET;
      height_setting = HEIGHT_RESET;
   endfunction

   // Appends one code to the end of the owed list.
   function automatic void owe_code(input lbp_result_type code);
      pending_codes = {pending_codes, code};
   endfunction

   // Advances the predictor by one pixel; returns 1 when the pixel completes a window.
   function automatic logic predict_pattern(input pixel_type px, input logic start,
                                            output lbp_result_type res);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      pixel_type   above;
      pixel_type   beside;
      pixel_type   center;
      logic        emit;
      w    = clamp_size(width_setting, MAX_WIDTH_DEF);
      h    = clamp_size(height_setting, MAX_HEIGHT_DEF);
      emit = 1'b0;
      res  = '0;

      // Frame start and any size change both resolve the position first.
      if (start) begin
         col_at = 0;
         row_at = 0;
      end
      if (col_at >= w) begin
         col_at = 0;
         row_at++;
      end
      if (row_at >= h) row_at = 0;
      col    = col_at;
      row    = row_at;
      above  = upper_row_px[col];
      beside = middle_row_px[col];

      // Clockwise from the top-left neighbor down to the left one.
      if (row >= 2 && col >= 2) begin
         center   = win_mid[1];
         res.code = {win_top[0] > center, win_top[1] > center, above > center,
                     beside > center, px > center, win_bot[1] > center,
                     win_bot[0] > center, win_mid[0] > center};
         res.last = (row == h - 1) && (col == w - 1);
         emit     = 1'b1;
      end

      win_top[0] = win_top[1];
      win_top[1] = above;
      win_mid[0] = win_mid[1];
      win_mid[1] = beside;
      win_bot[0] = win_bot[1];
      win_bot[1] = px;
      upper_row_px[col]  = beside;
      middle_row_px[col] = px;

      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_at = col;
      row_at = row;
      return emit;
   endfunction

   // Biased toward the extremes and toward near-equal values around mid grey.
   function automatic pixel_type sample_pixel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         2, 3: return pixel_type'(124 + $urandom_range(8));
         default: return pixel_type'($urandom_range(255));
      endcase
   endfunction

   function automatic void set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_RSP_HEAVY: begin
            send_idle_pct = 23;
            recv_idle_pct = 88;
         end
         IDLE_REQ_HEAVY: begin
            send_idle_pct = 88;
            recv_idle_pct = 23;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endfunction

   // Offers one pixel, waits for its transfer and records what it should produce.
   task automatic send_pixel(input pixel_type px, input logic start,
                             input row_check_type chk, input lbp_result_type typed);
      lbp_result_type predicted;
      logic           emit;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= px;
      req_frame_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      emit = predict_pattern(px, start, predicted);
      if (chk == ROW_MODEL) begin
         if (emit) owe_code(predicted);
      end else if (chk == ROW_CODE) begin
         owe_code(typed);
      end
   endtask

   // Sizes change only once the block has drained and no pixel is in flight.
   task automatic write_sizes(input logic [CSR_DATA_W-1:0] w_data,
                              input logic [CSR_DATA_W-1:0] h_data);
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w_data;
      @(posedge clock);
      width_setting = w_data[WIDTH_REG_W-1:0];
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h_data;
      @(posedge clock);
      height_setting = h_data[HEIGHT_REG_W-1:0];
      csr_we <= 1'b0;
   endtask

   // Mostly whole frames opened by a frame start, with some frames that just wrap
   // and a few frame starts dropped into the middle of a frame.
   task automatic run_phase(input size_phase_type phase);
      logic start;
      set_idle(phase.mode);
      write_sizes(phase.width_data, phase.height_data);
      for (int unsigned n = 0; n < phase.items; n++) begin
         if (col_at == 0 && row_at == 0) start = ($urandom_range(9) < 7);
         else start = ($urandom_range(99) < 2);
         send_pixel(sample_pixel(), start, ROW_MODEL, '0);
      end
   endtask

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Compare every transferred code with the oldest one owed.
   always @(posedge clock) begin : check_codes
      lbp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_codes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected code %02h last %0b", rsp_pattern_code, rsp_frame_last);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_pattern_code !== want.code || rsp_frame_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("code mismatch: expected %02h last %0b, got %02h last %0b",
                           want.code, want.last, rsp_pattern_code, rsp_frame_last);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("lbp_3x3_stream_core_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      clear_lbp_state();
      set_idle(IDLE_RSP_HEAVY);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the smallest size.
      write_sizes(13'd3, 13'd3);
      foreach (DIRECTED_ROWS[i])
         send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].chk,
                    lbp_result_type'({DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].last}));

      foreach (SIZE_PHASES[p]) run_phase(SIZE_PHASES[p]);

      // Drain, then leave room for any stray code.
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_codes.size() == 0) begin
         $display("lbp_3x3_stream_core_test OK");
      end else begin
         $display("lbp_3x3_stream_core_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lbp_pkg.sv
rtl/lbp_ram.sv
rtl/lbp_win.sv
rtl/lbp_rsp_queue.sv
rtl/lbp_3x3_stream_core.sv
verif/lbp_3x3_stream_core_test.sv
